/* rtl/lpc_bus_cycle_decoder_macros.svh */
// assertion macros shared by the lpc bus cycle decoder rtl
// expects i_clk and i_rst_n in the scope of the module that uses them
`ifndef LPC_BUS_CYCLE_DECODER_MACROS_SVH
`define LPC_BUS_CYCLE_DECODER_MACROS_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define LPCD_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("lpcd assertion failed");
// when ante holds, cons must hold at the next clock edge
`define LPCD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lpcd assertion failed");
`else
`define LPCD_ASSERT(lbl, cond)
`define LPCD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/lpcd_pkg.sv */
// shared types and codes for the lpc bus cycle decoder
// no dependencies
package lpcd_pkg;

    localparam int CFG_IDX_W = 3;

    typedef struct packed {
        logic [63:0] seq_no;
        logic [7:0]  sample_bits;
    } t_in_item;

    typedef struct packed {
        logic [63:0] start_seq;
        logic [1:0]  cycle_type;
        logic        is_write;
        logic [31:0] address;
        logic [7:0]  data_byte;
        logic [1:0]  status;
    } t_out_item;

    // probe positions of the bus signals
    typedef struct packed {
        logic [2:0] clock_bit;
        logic [2:0] frame_bit;
        logic [2:0] lad0_bit;
        logic [2:0] lad1_bit;
        logic [2:0] lad2_bit;
        logic [2:0] lad3_bit;
    } t_cfg;

    // bus signals picked out of one sample
    typedef struct packed {
        logic       clk;
        logic       frame;
        logic [3:0] lad;
    } t_probe;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLOCK_BIT = 3'd0,
        CFG_FRAME_BIT = 3'd1,
        CFG_LAD0_BIT  = 3'd2,
        CFG_LAD1_BIT  = 3'd3,
        CFG_LAD2_BIT  = 3'd4,
        CFG_LAD3_BIT  = 3'd5
    } t_cfg_idx;

    localparam t_cfg CFG_RESET = '{
        clock_bit: 3'd0, frame_bit: 3'd1,
        lad0_bit:  3'd5, lad1_bit:  3'd4,
        lad2_bit:  3'd3, lad3_bit:  3'd2
    };

    localparam logic [1:0] TYPE_IO  = 2'd0;
    localparam logic [1:0] TYPE_MEM = 2'd1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_ABORT = 2'd1;
    localparam logic [1:0] ST_UNSUP = 2'd2;

    localparam logic [3:0] START_TARGET = 4'h0;
    localparam logic [3:0] START_ABORT  = 4'hf;
    localparam logic [3:0] SYNC_READY   = 4'h0;

    localparam logic [3:0] ADDR_NIB_IO  = 4'd4;
    localparam logic [3:0] ADDR_NIB_MEM = 4'd8;
    localparam logic [1:0] TAR_CLOCKS   = 2'd2;
    localparam logic [1:0] DATA_NIBBLES = 2'd2;

endpackage

/* rtl/lpcd_probe_sel.sv */
// picks bus clock, frame and lad lines out of one logic analyzer sample
// depends on lpcd_pkg
module lpcd_probe_sel
    import lpcd_pkg::*;
(
    input  t_cfg       i_cfg,
    input  logic [7:0] i_sample,
    output t_probe     o_probe
);

    always_comb begin
        o_probe.clk    = i_sample[i_cfg.clock_bit];
        o_probe.frame  = i_sample[i_cfg.frame_bit];
        o_probe.lad[0] = i_sample[i_cfg.lad0_bit];
        o_probe.lad[1] = i_sample[i_cfg.lad1_bit];
        o_probe.lad[2] = i_sample[i_cfg.lad2_bit];
        o_probe.lad[3] = i_sample[i_cfg.lad3_bit];
    end

endmodule

/* rtl/lpc_bus_cycle_decoder.sv */
// lpc bus cycle decoder top level: sample channel, record channel, config port
// depends on lpcd_pkg, lpcd_probe_sel and lpc_bus_cycle_decoder_macros.svh
//
// usage
// - input channel (i_in_valid / o_in_ready / i_in) takes one logic analyzer
//   sample per item: sequence number and eight probe bits
// - output channel (o_out_valid / i_out_ready / o_out) gives one record per
//   finished, aborted or unsupported bus cycle; most samples give none
// - config port: i_cfg_we with i_cfg_idx and i_cfg_data sets the probe
//   position of clock, frame and lad0..lad3; write only while idle
// - records: a record is in the output register in the cycle after the sample
//   that closes the cycle is taken
// - throughput: one sample per clock while o_in_ready is high; the decoder
//   state and the output register both update in the cycle a sample is taken
// - stall: a record waits in the output register; o_in_ready stays high
//   while that register is empty or being emptied, so samples keep flowing
//   unless a record is stuck behind a stalled receiver
// - reset: probe positions return to their defaults, decoder goes idle
//   with clock seen low, output register empties
module lpc_bus_cycle_decoder
    import lpcd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [2:0]           i_cfg_data
);

`include "lpc_bus_cycle_decoder_macros.svh"

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_ADDR  = 3'd2,
        PH_DATA  = 3'd3,
        PH_TAR   = 3'd4,
        PH_SYNC  = 3'd5
    } t_phase;

    t_cfg        r_cfg;
    t_phase      r_phase, n_phase;
    t_phase      r_prior, n_prior;
    logic        r_clock_prev;
    logic [3:0]  r_start_nib, n_start_nib;
    logic [1:0]  r_kind, n_kind;
    logic        r_write, n_write;
    logic [3:0]  r_addr_left, n_addr_left;
    logic [31:0] r_addr, n_addr;
    logic [7:0]  r_data, n_data;
    logic [1:0]  r_data_idx, n_data_idx;
    logic [1:0]  r_tar_left, n_tar_left;
    logic [63:0] r_cycle_seq, n_cycle_seq;
    logic        r_out_valid;
    t_out_item   r_out;
    t_out_item   n_out;
    logic        n_emit;

    t_probe      w_probe;
    logic        w_acc;
    logic        w_fall;

    lpcd_probe_sel u_probe_sel (
        .i_cfg    (r_cfg),
        .i_sample (i_in.sample_bits),
        .o_probe  (w_probe)
    );

    // output register frees up in the same cycle it is taken
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign w_acc       = i_in_valid && o_in_ready;
    assign w_fall      = r_clock_prev && !w_probe.clk;

    // decoder step for one sample on a falling bus clock
    always_comb begin
        n_phase     = r_phase;
        n_prior     = r_prior;
        n_start_nib = r_start_nib;
        n_kind      = r_kind;
        n_write     = r_write;
        n_addr_left = r_addr_left;
        n_addr      = r_addr;
        n_data      = r_data;
        n_data_idx  = r_data_idx;
        n_tar_left  = r_tar_left;
        n_cycle_seq = r_cycle_seq;
        n_emit      = 1'b0;
        // record built from the state before this sample
        n_out.start_seq  = r_cycle_seq;
        n_out.cycle_type = r_kind;
        n_out.is_write   = r_write;
        n_out.address    = r_addr;
        n_out.data_byte  = r_data;
        n_out.status     = ST_DONE;

        if (w_fall) begin
            if (!w_probe.frame) begin
                // new frame: report an interrupted cycle, then restart
                if (r_phase == PH_ADDR || r_phase == PH_DATA ||
                    r_phase == PH_TAR || r_phase == PH_SYNC) begin
                    n_emit       = 1'b1;
                    n_out.status = ST_ABORT;
                end
                n_start_nib = w_probe.lad;
                n_cycle_seq = i_in.seq_no;
                n_addr      = '0;
                n_data      = '0;
                n_data_idx  = '0;
                n_prior     = PH_IDLE;
                n_phase     = PH_START;
            end else begin
                case (r_phase)
                    PH_START: begin
                        if (r_start_nib == START_TARGET) begin
                            n_kind  = w_probe.lad[3:2];
                            n_write = w_probe.lad[1];
                            n_addr  = '0;
                            n_prior = PH_START;
                            n_phase = PH_ADDR;
                            if (w_probe.lad[3:2] == TYPE_IO) begin
                                n_addr_left = ADDR_NIB_IO;
                            end else if (w_probe.lad[3:2] == TYPE_MEM) begin
                                n_addr_left = ADDR_NIB_MEM;
                            end else begin
                                // dma or reserved: report with cleared fields
                                n_phase          = PH_IDLE;
                                n_prior          = PH_IDLE;
                                n_data           = '0;
                                n_data_idx       = '0;
                                n_emit           = 1'b1;
                                n_out.cycle_type = w_probe.lad[3:2];
                                n_out.is_write   = w_probe.lad[1];
                                n_out.address    = '0;
                                n_out.data_byte  = '0;
                                n_out.status     = ST_UNSUP;
                            end
                        end else if (r_start_nib == START_ABORT) begin
                            n_phase    = PH_IDLE;
                            n_prior    = PH_IDLE;
                            n_addr     = '0;
                            n_data     = '0;
                            n_data_idx = '0;
                        end
                    end
                    PH_ADDR: begin
                        // most significant nibble first
                        n_addr_left = r_addr_left - 4'd1;
                        n_addr = r_addr | ({28'd0, w_probe.lad} << {n_addr_left[2:0], 2'b00});
                        if (n_addr_left == 4'd0) begin
                            n_prior = PH_ADDR;
                            if (r_write) begin
                                n_phase = PH_DATA;
                            end else begin
                                n_phase    = PH_TAR;
                                n_tar_left = TAR_CLOCKS;
                            end
                        end
                    end
                    PH_DATA: begin
                        // low nibble first
                        n_data     = r_data | ({4'd0, w_probe.lad} << {r_data_idx[0], 2'b00});
                        n_data_idx = r_data_idx + 2'd1;
                        if (n_data_idx == DATA_NIBBLES) begin
                            n_prior    = PH_DATA;
                            n_phase    = PH_TAR;
                            n_tar_left = TAR_CLOCKS;
                        end
                    end
                    PH_TAR: begin
                        n_tar_left = r_tar_left - 2'd1;
                        if (n_tar_left == 2'd0) begin
                            // first turnaround leads to sync, second ends the cycle
                            if (r_prior == (r_write ? PH_DATA : PH_ADDR)) begin
                                n_prior = PH_TAR;
                                n_phase = PH_SYNC;
                            end else begin
                                n_emit     = 1'b1;
                                n_phase    = PH_IDLE;
                                n_prior    = PH_IDLE;
                                n_addr     = '0;
                                n_data     = '0;
                                n_data_idx = '0;
                            end
                        end
                    end
                    PH_SYNC: begin
                        // waits for a ready sync code with no timeout
                        if (w_probe.lad == SYNC_READY) begin
                            n_prior = PH_SYNC;
                            if (r_write) begin
                                n_phase    = PH_TAR;
                                n_tar_left = TAR_CLOCKS;
                            end else begin
                                n_phase = PH_DATA;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // probe position registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CLOCK_BIT: r_cfg.clock_bit <= i_cfg_data;
                CFG_FRAME_BIT: r_cfg.frame_bit <= i_cfg_data;
                CFG_LAD0_BIT:  r_cfg.lad0_bit  <= i_cfg_data;
                CFG_LAD1_BIT:  r_cfg.lad1_bit  <= i_cfg_data;
                CFG_LAD2_BIT:  r_cfg.lad2_bit  <= i_cfg_data;
                CFG_LAD3_BIT:  r_cfg.lad3_bit  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // decoder state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_prior      <= PH_IDLE;
            r_clock_prev <= 1'b0;
            r_start_nib  <= '0;
            r_kind       <= '0;
            r_write      <= 1'b0;
            r_addr_left  <= '0;
            r_addr       <= '0;
            r_data       <= '0;
            r_data_idx   <= '0;
            r_tar_left   <= '0;
            r_cycle_seq  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_acc) begin
                r_clock_prev <= w_probe.clk;
                r_phase      <= n_phase;
                r_prior      <= n_prior;
                r_start_nib  <= n_start_nib;
                r_kind       <= n_kind;
                r_write      <= n_write;
                r_addr_left  <= n_addr_left;
                r_addr       <= n_addr;
                r_data       <= n_data;
                r_data_idx   <= n_data_idx;
                r_tar_left   <= n_tar_left;
                r_cycle_seq  <= n_cycle_seq;
            end
            if (w_acc && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && n_emit) begin
            r_out <= n_out;
        end
    end

    // no status code beyond unsupported is ever reported
    `LPCD_ASSERT(a_status_code, !o_out_valid || o_out.status <= ST_UNSUP)
    // unsupported records carry a dma or reserved type and cleared fields
    `LPCD_ASSERT(a_unsup_fields, !o_out_valid || o_out.status != ST_UNSUP ||
        (o_out.cycle_type[1] && o_out.address == 32'd0 && o_out.data_byte == 8'd0))
    // a completed io cycle only has a 16 bit address
    `LPCD_ASSERT(a_io_addr, !o_out_valid || o_out.status != ST_DONE ||
        o_out.cycle_type != TYPE_IO || o_out.address[31:16] == 16'd0)
    // address phase only runs for io or memory cycles with a sane count
    `LPCD_ASSERT(a_addr_kind, r_phase != PH_ADDR || (!r_kind[1] && r_addr_left <= ADDR_NIB_MEM))
    // samples that are not a falling bus clock never move the phase
    `LPCD_ASSERT_NEXT(a_no_edge_hold, w_acc && !w_fall, $stable(r_phase) && $stable(r_addr))

endmodule

/* verif/lpc_bus_cycle_decoder_tb.sv */
// self-checking testbench for lpc_bus_cycle_decoder: drives bus waveforms as analyzer samples
// and checks every record against a decoder model kept in this file
// depends on lpcd_pkg and the lpc_bus_cycle_decoder rtl
module lpc_bus_cycle_decoder_tb;
    import lpcd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] TYPE_DMA  = 2'd2;
    localparam logic [1:0] TYPE_RSVD = 2'd3;

    localparam int RX_ALWAYS  = 0;
    localparam int RX_RANDOM  = 1;
    localparam int RX_PATTERN = 2;

    localparam int LONG_HOLD    = 300;
    localparam int MAX_REPORTS  = 10;
    localparam int RANDOM_ITEMS = 750;
    localparam int ROUND_ITEMS  = 250;
    localparam int CYCLE_LIMIT  = 400000;

    typedef enum logic [2:0] {
        BP_IDLE, BP_START, BP_ADDR, BP_DATA, BP_TAR, BP_SYNC
    } t_bus_phase;

    // dut ports
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_ready;
    t_in_item   i_in        = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_item  o_out;
    logic       i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [2:0] i_cfg_data  = '0;

    // decoder model state
    t_cfg       cfg_now     = CFG_RESET;
    logic       seen_clk    = 1'b0;
    t_bus_phase bus_phase   = BP_IDLE;
    t_bus_phase last_phase  = BP_IDLE;
    logic [3:0] start_nib   = '0;
    logic [1:0] cyc_kind    = '0;
    logic       cyc_write   = 1'b0;
    logic [3:0] nib_left    = '0;
    logic [31:0] addr_acc   = '0;
    logic [7:0] data_acc    = '0;
    logic [1:0] data_pos    = '0;
    logic [1:0] tar_cnt     = '0;
    logic [63:0] frame_seq  = '0;

    t_out_item  pending_records[$];

    // stimulus and bookkeeping
    logic [63:0] next_seq   = '0;
    int         items_sent  = 0;
    int         records_seen = 0;
    int         fail_count  = 0;
    int         burst_left  = 0;
    bit         tx_gaps     = 1'b0;
    bit         jitter      = 1'b0;
    int         rx_mode     = RX_ALWAYS;
    int         hold_asks   = 0;
    int         hold_grants = 0;
    int         hold_left   = 0;
    int         rx_tick     = 0;
    int         cycle_count = 0;

    lpc_bus_cycle_decoder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------------------------------------------------------- decoder model

    function automatic t_out_item cur_record(input logic [1:0] st);
        t_out_item r;
        r.start_seq  = frame_seq;
        r.cycle_type = cyc_kind;
        r.is_write   = cyc_write;
        r.address    = addr_acc;
        r.data_byte  = data_acc;
        r.status     = st;
        return r;
    endfunction

    task automatic clear_cycle();
        bus_phase  = BP_IDLE;
        last_phase = BP_IDLE;
        addr_acc   = '0;
        data_acc   = '0;
        data_pos   = '0;
    endtask

    task automatic enter_phase(input t_bus_phase nxt);
        last_phase = bus_phase;
        bus_phase  = nxt;
    endtask

    // the current phase ran out: pick the next one in read or write order
    task automatic finish_phase();
        case (bus_phase)
            BP_ADDR: begin
                if (cyc_write) begin
                    enter_phase(BP_DATA);
                end else begin
                    enter_phase(BP_TAR);
                    tar_cnt = TAR_CLOCKS;
                end
            end
            BP_DATA: begin
                enter_phase(BP_TAR);
                tar_cnt = TAR_CLOCKS;
            end
            BP_TAR: begin
                // first turnaround leads to sync, the second one closes the cycle
                if (last_phase == (cyc_write ? BP_DATA : BP_ADDR)) begin
                    enter_phase(BP_SYNC);
                end else begin
                    pending_records.push_back(cur_record(ST_DONE));
                    clear_cycle();
                end
            end
            BP_SYNC: begin
                if (cyc_write) begin
                    enter_phase(BP_TAR);
                    tar_cnt = TAR_CLOCKS;
                end else begin
                    enter_phase(BP_DATA);
                end
            end
            default: ;
        endcase
    endtask

    task automatic decode_sample(input t_in_item it);
        logic       clk_now;
        logic       frame_now;
        logic [3:0] lad;
        clk_now = it.sample_bits[cfg_now.clock_bit];
        // only a falling bus clock moves the decoder
        if (seen_clk && !clk_now) begin
            frame_now = it.sample_bits[cfg_now.frame_bit];
            lad = {it.sample_bits[cfg_now.lad3_bit], it.sample_bits[cfg_now.lad2_bit],
                   it.sample_bits[cfg_now.lad1_bit], it.sample_bits[cfg_now.lad0_bit]};
            if (!frame_now) begin
                if (bus_phase != BP_IDLE && bus_phase != BP_START)
                    pending_records.push_back(cur_record(ST_ABORT));
                start_nib = lad;
                frame_seq = it.seq_no;
                clear_cycle();
                enter_phase(BP_START);
            end else begin
                case (bus_phase)
                    BP_START: begin
                        if (start_nib == START_TARGET) begin
                            cyc_kind  = lad[3:2];
                            cyc_write = lad[1];
                            addr_acc  = '0;
                            enter_phase(BP_ADDR);
                            if (cyc_kind == TYPE_IO) begin
                                nib_left = ADDR_NIB_IO;
                            end else if (cyc_kind == TYPE_MEM) begin
                                nib_left = ADDR_NIB_MEM;
                            end else begin
                                clear_cycle();
                                pending_records.push_back(cur_record(ST_UNSUP));
                            end
                        end else if (start_nib == START_ABORT) begin
                            clear_cycle();
                        end
                    end
                    BP_ADDR: begin
                        nib_left = nib_left - 4'd1;
                        addr_acc = addr_acc | ({28'd0, lad} << {nib_left[2:0], 2'b00});
                        if (nib_left == 4'd0)
                            finish_phase();
                    end
                    BP_DATA: begin
                        data_acc = data_acc | ({4'd0, lad} << {data_pos[0], 2'b00});
                        data_pos = data_pos + 2'd1;
                        if (data_pos == DATA_NIBBLES)
                            finish_phase();
                    end
                    BP_TAR: begin
                        tar_cnt = tar_cnt - 2'd1;
                        if (tar_cnt == 2'd0)
                            finish_phase();
                    end
                    BP_SYNC: begin
                        if (lad == SYNC_READY)
                            finish_phase();
                    end
                    default: ;
                endcase
            end
        end
        seen_clk = clk_now;
    endtask

    // ---------------------------------------------------------------- record checking

    task automatic field_check(input string name, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (want_v !== got_v) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("record field %s: expected %h, got %h", name, want_v, got_v);
        end
    endtask

    // output handshake is stable at the falling edge; the record is taken at the next rise
    always @(negedge i_clk) begin : check_records
        t_out_item got;
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = o_out;
            records_seen++;
            if (pending_records.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("record with nothing pending: %h", got);
            end else begin
                want = pending_records.pop_front();
                field_check("start_seq",  want.start_seq,  got.start_seq);
                field_check("cycle_type", 64'(want.cycle_type), 64'(got.cycle_type));
                field_check("is_write",   64'(want.is_write),   64'(got.is_write));
                field_check("address",    64'(want.address),    64'(got.address));
                field_check("data_byte",  64'(want.data_byte),  64'(got.data_byte));
                field_check("status",     64'(want.status),     64'(got.status));
            end
        end
    end

    // ---------------------------------------------------------------- record receiver

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_asks != hold_grants) begin
            // long hold-off so the decoder fills up and stalls its input
            hold_grants <= hold_grants + 1;
            hold_left   <= LONG_HOLD;
            i_out_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: i_out_ready <= 1'b1;
                RX_RANDOM: i_out_ready <= ($urandom_range(0, 9) < 6);
                default:   i_out_ready <= ((rx_tick % 11) < 7);
            endcase
        end
        rx_tick <= rx_tick + 1;
    end

    // ---------------------------------------------------------------- sample sender

    // one sample item; called at a rising edge, returns at the edge that takes it
    task automatic send_sample(input logic [7:0] bits);
        t_in_item it;
        logic     took;
        if (tx_gaps && burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        if (burst_left > 0)
            burst_left--;
        it.seq_no      = next_seq;
        it.sample_bits = bits;
        next_seq       = next_seq + 64'd1;
        i_in_valid <= 1'b1;
        i_in       <= it;
        took = 1'b0;
        while (!took) begin
            @(negedge i_clk);
            took = o_in_ready;
            @(posedge i_clk);
        end
        decode_sample(it);
        items_sent++;
    endtask

    // probe levels placed at the configured positions, other probes random
    function automatic logic [7:0] make_sample(input logic clk, input logic frame,
                                               input logic [3:0] lad);
        logic [7:0] b;
        b = 8'($urandom);
        b[cfg_now.lad0_bit]  = lad[0];
        b[cfg_now.lad1_bit]  = lad[1];
        b[cfg_now.lad2_bit]  = lad[2];
        b[cfg_now.lad3_bit]  = lad[3];
        b[cfg_now.frame_bit] = frame;
        b[cfg_now.clock_bit] = clk;
        return b;
    endfunction

    // one bus clock: high samples, the falling edge carrying frame and lad, then any further low samples
    task automatic bus_clock(input logic frame, input logic [3:0] lad);
        int hi;
        int lo;
        hi = jitter ? $urandom_range(1, 3) : 1;
        lo = jitter ? $urandom_range(1, 3) : 1;
        repeat (hi) send_sample(make_sample(1'b1, 1'($urandom), 4'($urandom)));
        send_sample(make_sample(1'b0, frame, lad));
        repeat (lo - 1) send_sample(make_sample(1'b0, 1'($urandom), 4'($urandom)));
    endtask

    // a whole target cycle; cut_after > 0 keeps only that many clocks after the frame
    task automatic bus_cycle(input logic [1:0] kind, input logic wr, input logic [31:0] addr,
                             input logic [7:0] data, input int sync_wait, input int cut_after);
        logic [4:0] clock_plan[$];
        int         n;
        clock_plan.push_back({1'b0, START_TARGET});
        clock_plan.push_back({1'b1, kind, wr, 1'($urandom)});
        if (kind == TYPE_IO || kind == TYPE_MEM) begin
            n = (kind == TYPE_IO) ? 4 : 8;
            for (int i = n - 1; i >= 0; i--)
                clock_plan.push_back({1'b1, addr[i*4 +: 4]});
            if (wr) begin
                clock_plan.push_back({1'b1, data[3:0]});
                clock_plan.push_back({1'b1, data[7:4]});
            end
            repeat (2) clock_plan.push_back({1'b1, 4'($urandom)});
            repeat (sync_wait) clock_plan.push_back({1'b1, 4'($urandom_range(1, 15))});
            clock_plan.push_back({1'b1, SYNC_READY});
            if (!wr) begin
                clock_plan.push_back({1'b1, data[3:0]});
                clock_plan.push_back({1'b1, data[7:4]});
            end
            repeat (2) clock_plan.push_back({1'b1, 4'($urandom)});
        end
        if (cut_after > 0)
            while (clock_plan.size() > cut_after + 1)
                void'(clock_plan.pop_back());
        foreach (clock_plan[i])
            bus_clock(clock_plan[i][4], clock_plan[i][3:0]);
    endtask

    // sender stops until every record is in, then lets the last sample settle
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_records.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // writes every index of the port; the ones past the list must be ignored
    task automatic set_probe_map(input t_cfg m);
        logic [CFG_IDX_W-1:0] idx;
        logic [2:0]           val;
        for (int k = 0; k < (1 << CFG_IDX_W); k++) begin
            idx = k[CFG_IDX_W-1:0];
            case (idx)
                CFG_CLOCK_BIT: val = m.clock_bit;
                CFG_FRAME_BIT: val = m.frame_bit;
                CFG_LAD0_BIT:  val = m.lad0_bit;
                CFG_LAD1_BIT:  val = m.lad1_bit;
                CFG_LAD2_BIT:  val = m.lad2_bit;
                CFG_LAD3_BIT:  val = m.lad3_bit;
                default:       val = 3'($urandom);
            endcase
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx;
            i_cfg_data <= val;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cfg_now = m;
    endtask

    // ---------------------------------------------------------------- tests

    // reset probe map, clean handshakes, one case per line
    task automatic test_directed_cycles();
        jitter  = 1'b0;
        tx_gaps = 1'b0;
        rx_mode = RX_ALWAYS;
        // frame sample lands on the all-ones sequence number, then on zero
        next_seq = 64'hffff_ffff_ffff_fffe;
        bus_cycle(TYPE_IO, 1'b0, 32'h0000_ffff, 8'hff, 1, 0);
        next_seq = 64'hffff_ffff_ffff_ffff;
        bus_cycle(TYPE_IO, 1'b1, 32'h0, 8'h00, 0, 0);
        bus_cycle(TYPE_MEM, 1'b1, 32'hffff_ffff, 8'ha5, 0, 0);
        bus_cycle(TYPE_MEM, 1'b0, 32'h0, 8'h5a, 2, 0);
        // dma and reserved types give an unsupported record right away
        bus_cycle(TYPE_DMA, 1'b0, 32'h0, 8'h00, 0, 0);
        bus_cycle(TYPE_DMA, 1'b1, 32'h0, 8'h00, 0, 0);
        bus_cycle(TYPE_RSVD, 1'b0, 32'h0, 8'h00, 0, 0);
        bus_cycle(TYPE_RSVD, 1'b1, 32'h0, 8'h00, 0, 0);
        // new frame in the middle of each phase
        bus_cycle(TYPE_MEM, 1'b0, 32'h1234_5678, 8'h00, 0, 3);
        bus_cycle(TYPE_IO, 1'b1, 32'h0000_beef, 8'h3c, 0, 6);
        bus_cycle(TYPE_IO, 1'b0, 32'h0000_1357, 8'h00, 0, 6);
        bus_cycle(TYPE_IO, 1'b0, 32'h0000_2468, 8'h00, 3, 8);
        bus_cycle(TYPE_IO, 1'b1, 32'h0000_9abc, 8'h96, 0, 11);
        bus_cycle(TYPE_MEM, 1'b0, 32'h0, 8'h00, 0, 1);
        bus_cycle(TYPE_IO, 1'b0, 32'h0000_7777, 8'h81, 0, 0);
        // abort start nibble: back to idle, the following clocks are ignored
        bus_clock(1'b0, START_ABORT);
        repeat (3) bus_clock(1'b1, 4'h0);
        // other start nibble parks in start; a new frame there gives no record
        bus_clock(1'b0, 4'h5);
        repeat (3) bus_clock(1'b1, 4'h0);
        // frame held low over back-to-back clocks, last nibble counts
        bus_clock(1'b0, 4'h3);
        bus_cycle(TYPE_IO, 1'b1, 32'h0000_0f0f, 8'hf0, 0, 0);
        // sync waits as long as lad stays non-zero
        bus_cycle(TYPE_MEM, 1'b1, 32'h8000_0001, 8'h7e, 12, 0);
        bus_cycle(TYPE_IO, 1'b0, 32'h0000_4001, 8'he7, 12, 0);
        // unchanged clock levels, rising edges and a falling edge with frame high do nothing
        repeat (3) send_sample(make_sample(1'b1, 1'b0, 4'($urandom)));
        repeat (3) send_sample(make_sample(1'b0, 1'b1, 4'($urandom)));
        send_sample(make_sample(1'b1, 1'b0, 4'h0));
        wait_drained();
    endtask

    // receiver holds off while the sender keeps going, so the input must stall
    task automatic test_output_stall();
        jitter  = 1'b0;
        tx_gaps = 1'b0;
        rx_mode = RX_ALWAYS;
        hold_asks++;
        repeat (8) bus_cycle(TYPE_IO, 1'($urandom), 32'($urandom), 8'($urandom), 0, 0);
        wait_drained();
    endtask

    // overlapping and edge probe positions
    task automatic test_probe_extremes();
        jitter  = 1'b1;
        tx_gaps = 1'b1;
        rx_mode = RX_RANDOM;
        set_probe_map('{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0});
        repeat (40) send_sample(8'($urandom));
        wait_drained();
        set_probe_map('{3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7});
        repeat (40) send_sample(8'($urandom));
        wait_drained();
        // clock on the top probe, frame on the bottom one
        set_probe_map('{3'd7, 3'd0, 3'd6, 3'd5, 3'd2, 3'd1});
        repeat (4) bus_cycle(TYPE_MEM, 1'($urandom), 32'($urandom), 8'($urandom), 1, 0);
        wait_drained();
        // clock on a lad probe: mostly noise
        set_probe_map('{3'd3, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0});
        repeat (60) send_sample(8'($urandom));
        bus_cycle(TYPE_IO, 1'b1, 32'($urandom), 8'($urandom), 0, 0);
        wait_drained();
    endtask

    // rounds of random probe maps, handshake modes and mixed bus traffic
    task automatic test_random_traffic();
        int         items_at_start;
        int         round_items;
        int         round_records;
        int         pick;
        int         j;
        logic [2:0] pos[8];
        logic [2:0] tmp;
        t_cfg       m;
        items_at_start = items_sent;
        while (items_sent - items_at_start < RANDOM_ITEMS) begin
            wait_drained();
            for (int i = 0; i < 8; i++)
                pos[i] = 3'(i);
            for (int i = 7; i > 0; i--) begin
                j = $urandom_range(0, i);
                tmp = pos[i];
                pos[i] = pos[j];
                pos[j] = tmp;
            end
            m = '{pos[0], pos[1], pos[2], pos[3], pos[4], pos[5]};
            set_probe_map(m);
            tx_gaps = ($urandom_range(0, 3) != 0);
            jitter  = ($urandom_range(0, 1) != 0);
            rx_mode = $urandom_range(RX_ALWAYS, RX_PATTERN);
            round_items   = items_sent;
            round_records = records_seen;
            while (items_sent - round_items < ROUND_ITEMS || records_seen - round_records < 8) begin
                pick = $urandom_range(0, 99);
                if ($urandom_range(0, 9) == 0)
                    bus_clock(1'b0, 4'($urandom));
                if (pick < 60) begin
                    bus_cycle(($urandom_range(0, 3) != 0) ? TYPE_IO : TYPE_MEM,
                              1'($urandom), 32'($urandom), 8'($urandom),
                              ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12)
                                                          : $urandom_range(0, 2), 0);
                end else if (pick < 72) begin
                    bus_cycle(($urandom_range(0, 1) != 0) ? TYPE_IO : TYPE_MEM,
                              1'($urandom), 32'($urandom), 8'($urandom),
                              $urandom_range(0, 3), $urandom_range(1, 24));
                end else if (pick < 80) begin
                    bus_cycle(($urandom_range(0, 1) != 0) ? TYPE_DMA : TYPE_RSVD,
                              1'($urandom), 32'h0, 8'h00, 0, 0);
                end else if (pick < 86) begin
                    bus_clock(1'b0, ($urandom_range(0, 1) != 0) ? START_ABORT
                                                                : 4'($urandom_range(1, 14)));
                    repeat ($urandom_range(1, 4)) bus_clock(1'b1, 4'($urandom));
                end else if (pick < 92) begin
                    repeat ($urandom_range(1, 6)) send_sample(8'($urandom));
                end else begin
                    repeat ($urandom_range(1, 4)) bus_clock(1'b1, 4'($urandom));
                end
                // now and then the sender waits for every record
                if ($urandom_range(0, 49) == 0)
                    wait_drained();
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cycles();
        test_output_stall();
        test_probe_extremes();
        test_random_traffic();
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (pending_records.size() != 0)
            fail_count++;
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
